@@ rtl/uart_tx_fifo_serializer_defines.svh @@
// assertion macros shared by the checker of the uart transmitter
// no dependencies; include by bare file name
`ifndef UART_TX_FIFO_SERIALIZER_DEFINES_SVH
`define UART_TX_FIFO_SERIALIZER_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define UTFS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define UTFS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/utfs_pkg.sv @@
// shared types, constants and frame builder for the uart transmitter
// no dependencies
package utfs_pkg;

    localparam int QUEUE_DEPTH   = 16;
    localparam int PTR_W         = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W         = $clog2(QUEUE_DEPTH + 1);
    localparam int DATA_W        = 8;
    localparam int FRAME_W       = 12;
    localparam int OUT_FIELDS_W  = 3 + CNT_W;
    localparam int OUT_TDATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam logic [1:0] STOP_PAIR = 2'b11;

    // opcode carried in tuser
    localparam logic OP_TICK    = 1'b0;
    localparam logic OP_ENQUEUE = 1'b1;

    // register index, taken from paddr[2]
    localparam logic REG_PARITY_EN   = 1'b0;
    localparam logic REG_PARITY_SEED = 1'b1;

    typedef struct packed {
        logic [CNT_W-1:0] count_next;
        logic             empty;
        logic             full;
    } t_fifo_stat;

    typedef struct packed {
        logic line_next;
        logic frame_busy_next;
    } t_ser_stat;

    // start bit, data lsb first, optional parity, two stop bits
    function automatic logic [FRAME_W-1:0] build_frame(
        input logic [DATA_W-1:0] data,
        input logic              par_en,
        input logic              par_seed
    );
        logic par;
        par = par_seed ^ (^data);
        if (par_en) begin
            return {STOP_PAIR, par, data, 1'b0};
        end
        return FRAME_W'({STOP_PAIR, data, 1'b0});
    endfunction

endpackage

@@ rtl/utfs_fifo.sv @@
// byte ring buffer with fill count and registered head read
// depends on utfs_pkg
module utfs_fifo
    import utfs_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_pop,
    output logic [DATA_W-1:0] o_head,
    output t_fifo_stat        o_stat
);

    logic [DATA_W-1:0] r_mem [QUEUE_DEPTH];
    logic [DATA_W-1:0] r_head;
    logic [PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [CNT_W-1:0]  r_count, n_count;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_comb begin
        n_rd_ptr = i_pop  ? ptr_inc(r_rd_ptr) : r_rd_ptr;
        n_wr_ptr = i_push ? ptr_inc(r_wr_ptr) : r_wr_ptr;
        priority if (i_push) begin
            n_count = r_count + CNT_W'(1);
        end else if (i_pop) begin
            n_count = r_count - CNT_W'(1);
        end else begin
            n_count = r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr <= '0;
            r_wr_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_rd_ptr <= n_rd_ptr;
            r_wr_ptr <= n_wr_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    // head register tracks the next read slot, bypassing a same-cycle write
    always_ff @(posedge i_clk) begin
        if (i_push && (r_wr_ptr == n_rd_ptr)) begin
            r_head <= i_wdata;
        end else begin
            r_head <= r_mem[n_rd_ptr];
        end
    end

    assign o_head            = r_head;
    assign o_stat.count_next = n_count;
    assign o_stat.empty      = (r_count == '0);
    assign o_stat.full       = (r_count >= CNT_W'(QUEUE_DEPTH));

endmodule

@@ rtl/utfs_frame_ser.sv @@
// frame shift register and line level driver
// depends on utfs_pkg
module utfs_frame_ser
    import utfs_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_tick,
    input  logic              i_empty,
    input  logic [DATA_W-1:0] i_head,
    input  logic              i_par_en,
    input  logic              i_par_seed,
    output logic              o_pop,
    output t_ser_stat         o_stat
);

    logic [FRAME_W-1:0] r_shift, n_shift;
    logic               r_line, n_line;
    logic               pop;

    always_comb begin
        n_shift = r_shift;
        n_line  = r_line;
        pop     = 1'b0;
        if (i_tick) begin
            priority if (r_shift != '0) begin
                n_line  = r_shift[0];
                n_shift = r_shift >> 1;
            end else if (!i_empty) begin
                // load tick: line keeps its level
                pop     = 1'b1;
                n_shift = build_frame(i_head, i_par_en, i_par_seed);
            end else begin
                n_shift = r_shift;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift <= '0;
            r_line  <= 1'b1;
        end else begin
            r_shift <= n_shift;
            r_line  <= n_line;
        end
    end

    assign o_pop                  = pop;
    assign o_stat.line_next       = n_line;
    assign o_stat.frame_busy_next = (n_shift != '0);

endmodule

@@ rtl/uart_tx_fifo_serializer.sv @@
// top level of the uart transmitter: stream ports, apb registers, result register
// depends on utfs_pkg, utfs_fifo, utfs_frame_ser
//
// usage
//   input stream: each beat is an enqueue (tuser = 1, byte in tdata) or a baud
//   tick (tuser = 0, tdata ignored). an enqueue stores the byte if the 16-entry
//   queue has room, else reports busy. a tick shifts one frame bit onto the
//   line, or loads the next frame from the queue when the shifter is empty
//   (the line keeps its level on a load tick). frame: start, 8 data lsb first,
//   optional parity, two stop bits.
//   output stream: exactly one result beat per input beat, in order, with the
//   line level, busy status, queue count and active flag after that beat.
//   latency: the result beat is valid in the cycle after the input beat.
//   throughput: one beat per cycle; each item is a single pointer, count and
//   shifter update between the input handshake and the result register.
//   stall: the result register holds while i_m_axis_tready is low; a new input
//   beat is taken in the same cycle the held result is taken, so there is no
//   bubble. tready drops only while a result waits and the sink stalls.
//   reset: queue empty, shifter empty, line at idle mark, parity off, seed 0,
//   no result pending. queue contents are not cleared.
//   apb: reg 0 at 0x0 parity_enable, reg 1 at 0x4 parity_seed; write only
//   while idle
module uart_tx_fifo_serializer
    import utfs_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,

    // input stream
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [DATA_W-1:0]      i_s_axis_tdata,   // [7:0] data_byte
    input  logic [0:0]             i_s_axis_tuser,   // [0] opcode

    // result stream
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // [0] tx_line, [1] status, [CNT_W+1:2] queue_count, [CNT_W+2] active
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,

    // configuration
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [2:0]             paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    logic                    r_par_en;
    logic                    r_par_seed;
    logic                    r_out_valid, n_out_valid;
    logic [OUT_FIELDS_W-1:0] r_out_data;

    logic                    in_beat;
    logic                    is_enq;
    logic                    push;
    logic                    tick;
    logic                    pop;
    logic                    busy;
    logic [DATA_W-1:0]       head;
    t_fifo_stat              fifo_stat;
    t_ser_stat               ser_stat;
    logic                    cfg_wr;

    // handshake: take a beat whenever the result register is free or draining
    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign in_beat         = i_s_axis_tvalid && o_s_axis_tready;
    assign is_enq          = (i_s_axis_tuser[0] == OP_ENQUEUE);
    assign push            = in_beat && is_enq && !fifo_stat.full;
    assign tick            = in_beat && !is_enq;
    assign busy            = is_enq && fifo_stat.full;

    utfs_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata (i_s_axis_tdata),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (fifo_stat)
    );

    utfs_frame_ser u_ser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_tick     (tick),
        .i_empty    (fifo_stat.empty),
        .i_head     (head),
        .i_par_en   (r_par_en),
        .i_par_seed (r_par_seed),
        .o_pop      (pop),
        .o_stat     (ser_stat)
    );

    // result register
    always_comb begin
        priority if (in_beat) begin
            n_out_valid = 1'b1;
        end else if (i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    // payload needs no reset
    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_out_data <= {ser_stat.frame_busy_next || (fifo_stat.count_next != '0),
                           fifo_stat.count_next,
                           busy,
                           ser_stat.line_next};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OUT_TDATA_W'(r_out_data);

    // apb registers, decoded on paddr[2]
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_par_en   <= 1'b0;
            r_par_seed <= 1'b0;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_PARITY_EN: begin
                    r_par_en <= pwdata[0];
                end
                REG_PARITY_SEED: begin
                    r_par_seed <= pwdata[0];
                end
                default: begin
                    r_par_en <= r_par_en;
                end
            endcase
        end
    end

    assign prdata = {31'd0, (paddr[2] == REG_PARITY_SEED) ? r_par_seed : r_par_en};

endmodule

@@ rtl/utfs_checker.sv @@
// port-level checker for the uart transmitter, bound to the top level
// depends on utfs_pkg and uart_tx_fifo_serializer_defines.svh
`include "uart_tx_fifo_serializer_defines.svh"

module utfs_checker
    import utfs_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   o_s_axis_tready,
    input logic                   o_m_axis_tvalid,
    input logic                   i_m_axis_tready,
    input logic [OUT_TDATA_W-1:0] o_m_axis_tdata
);

    logic [CNT_W-1:0] res_count;
    logic             res_status;
    logic             res_active;

    assign res_count  = o_m_axis_tdata[CNT_W+1:2];
    assign res_status = o_m_axis_tdata[1];
    assign res_active = o_m_axis_tdata[CNT_W+2];

    `UTFS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata), "result beat changed while stalled")
    `UTFS_ASSERT_NOW(a_ready_free, i_clk, i_rst_n, !o_m_axis_tvalid || i_m_axis_tready, o_s_axis_tready, "input stalled while result path is free")
    `UTFS_ASSERT_NOW(a_busy_full, i_clk, i_rst_n, o_m_axis_tvalid && res_status, res_count == CNT_W'(QUEUE_DEPTH), "busy reported with room in the queue")
    `UTFS_ASSERT_NOW(a_idle_empty, i_clk, i_rst_n, o_m_axis_tvalid && !res_active, res_count == '0, "inactive while bytes wait")

endmodule

bind uart_tx_fifo_serializer utfs_checker u_utfs_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

@@ tb/tb_uart_tx_fifo_serializer.sv @@
// self-checking testbench for the uart transmitter with byte queue
// depends on utfs_pkg and uart_tx_fifo_serializer; runs on its own
`timescale 1ns / 100ps

module tb_uart_tx_fifo_serializer;
    import utfs_pkg::*;

    // one result beat as the block reports it
    typedef struct packed {
        logic             active;
        logic [CNT_W-1:0] depth;
        logic             busy;
        logic             line;
    } t_tx_status;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    logic [DATA_W-1:0]      i_s_axis_tdata = '0;   // [7:0] data_byte
    logic [0:0]             i_s_axis_tuser = '0;   // [0] opcode
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    // [0] tx_line, [1] status, [CNT_W+1:2] queue_count, [CNT_W+2] active
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [2:0]             paddr = '0;
    logic [31:0]            pwdata = '0;
    logic [31:0]            prdata;
    logic                   pready;

    // shadow copy of the transmitter: queue, pointers, shifter, line, parity setup
    logic [DATA_W-1:0]      q_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]       q_rd;
    logic [PTR_W-1:0]       q_wr;
    logic [CNT_W-1:0]       q_fill;
    logic [FRAME_W-1:0]     shreg;
    logic                   line_q;
    logic                   cfg_par_en;
    logic                   cfg_par_odd;

    // status beats the block still owes, oldest first
    t_tx_status             tx_status_q [$];

    int                     mismatches = 0;
    int                     src_gap_max = 0;
    int                     snk_gap_max = 0;

    uart_tx_fifo_serializer dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    // 12 ns period
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // apply one beat to the shadow state and return the status it should produce
    function automatic t_tx_status advance_tx(input logic op, input logic [DATA_W-1:0] b);
        t_tx_status       r;
        logic             par;
        logic [DATA_W-1:0] byte_out;
        r.busy = 1'b0;
        if (op == OP_ENQUEUE) begin
            // full queue drops the byte and flags busy, nothing else moves
            if (q_fill == CNT_W'(QUEUE_DEPTH)) begin
                r.busy = 1'b1;
            end else begin
                q_mem[q_wr] = b;
                q_wr = (q_wr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : q_wr + 1'b1;
                q_fill = q_fill + 1'b1;
            end
        end else if (shreg != '0) begin
            // frame in flight: drive the low bit, shift right
            line_q = shreg[0];
            shreg = shreg >> 1;
        end else if (q_fill != '0) begin
            // load tick: pop and build the frame, line keeps its level
            byte_out = q_mem[q_rd];
            par = cfg_par_odd ^ (^byte_out);
            if (cfg_par_en) begin
                shreg = {2'b11, par, byte_out, 1'b0};
            end else begin
                shreg = {1'b0, 2'b11, byte_out, 1'b0};
            end
            q_rd = (q_rd == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : q_rd + 1'b1;
            q_fill = q_fill - 1'b1;
        end
        // empty shifter and empty queue on a tick: no change
        r.line = line_q;
        r.depth = q_fill;
        r.active = (shreg != '0) || (q_fill != '0);
        return r;
    endfunction

    // send one beat on the input stream; entered and left at a falling edge
    task automatic send_beat(input logic op, input logic [DATA_W-1:0] b);
        int gap;
        gap = $urandom_range(0, src_gap_max);
        if (gap > 0) begin
            i_s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tuser = op;
        i_s_axis_tdata = b;
        do @(posedge i_clk); while (o_s_axis_tready !== 1'b1);
        // beat taken at this edge: predict its status now
        tx_status_q.push_back(advance_tx(op, b));
        @(negedge i_clk);
    endtask

    task automatic send_tick();
        send_beat(OP_TICK, DATA_W'($urandom_range(0, 255)));
    endtask

    // wait until every owed beat has come back, then a few quiet cycles
    task automatic settle();
        i_s_axis_tvalid = 1'b0;
        while (tx_status_q.size() != 0) @(negedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    // apb write: setup then access phase, register taken when pready is high
    task automatic write_reg(input logic idx, input logic val);
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = {idx, 2'b00};
        pwdata = {31'b0, val};
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        if (idx == REG_PARITY_EN) begin
            cfg_par_en = val;
        end else begin
            cfg_par_odd = val;
        end
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic set_parity(input logic en, input logic odd);
        settle();
        write_reg(REG_PARITY_EN, en);
        write_reg(REG_PARITY_SEED, odd);
    endtask

    // tick until the shadow says the line is quiet, then one idle tick
    task automatic drain_line();
        while (shreg != '0 || q_fill != '0) send_tick();
        send_tick();
    endtask

    // directed: empty tick, byte extremes, queue full and busy, reuse after pop
    task automatic test_directed();
        logic [DATA_W-1:0] pat [6];
        pat = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'hAA, 8'h55};
        src_gap_max = 0;
        snk_gap_max = 0;
        send_tick();                          // tick with nothing to send
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            send_beat(OP_ENQUEUE, (i < 6) ? pat[i] : DATA_W'($urandom_range(0, 255)));
        end
        send_beat(OP_ENQUEUE, 8'hFF);         // queue full, busy
        send_tick();                          // frame load, one slot freed
        send_beat(OP_ENQUEUE, 8'h00);         // fills the freed slot
        send_beat(OP_ENQUEUE, 8'h5A);         // queue still full, busy
        repeat (3) send_tick();               // start bit and first data bits
    endtask

    // every parity setting, each with a short queue drained on the line
    task automatic test_parity_modes();
        logic [1:0] modes [4];
        modes = '{2'b10, 2'b11, 2'b01, 2'b00};
        foreach (modes[m]) begin
            src_gap_max = (m % 2) ? 18 : 0;
            snk_gap_max = (m < 2) ? 18 : 0;
            set_parity(modes[m][1], modes[m][0]);
            send_beat(OP_ENQUEUE, 8'h00);
            send_beat(OP_ENQUEUE, 8'hFF);
            send_beat(OP_ENQUEUE, DATA_W'($urandom_range(0, 255)));
            drain_line();
        end
    endtask

    // random phases: mostly bursts of bytes followed by ticks, some loose beats
    task automatic test_random(input int n_phases, input int per_phase);
        int n;
        int k;
        int t;
        for (int p = 0; p < n_phases; p++) begin
            set_parity(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            case (p % 4)
                0: begin
                    src_gap_max = 0;
                    snk_gap_max = 0;
                end
                1: begin
                    src_gap_max = 0;
                    snk_gap_max = 18;
                end
                2: begin
                    src_gap_max = 18;
                    snk_gap_max = 0;
                end
                default: begin
                    src_gap_max = 18;
                    snk_gap_max = 18;
                end
            endcase
            n = 0;
            while (n < per_phase) begin
                if ($urandom_range(0, 9) < 7) begin
                    // burst may overrun the queue and draw busy replies
                    k = $urandom_range(1, 20);
                    repeat (k) send_beat(OP_ENQUEUE, DATA_W'($urandom_range(0, 255)));
                    t = $urandom_range(k * 6, k * 16);
                    repeat (t) send_tick();
                    n += k + t;
                end else begin
                    send_beat(1'($urandom_range(0, 1)), DATA_W'($urandom_range(0, 255)));
                    n++;
                end
            end
        end
    endtask

    // result sink: random stall per beat, then ready until a beat is taken
    initial begin : sink_ready
        int stall;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            stall = $urandom_range(0, snk_gap_max);
            if (stall > 0) begin
                i_m_axis_tready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_m_axis_tready = 1'b1;
            do @(posedge i_clk); while (o_m_axis_tvalid !== 1'b1);
            @(negedge i_clk);
        end
    end

    // compare each result beat with the oldest prediction
    always @(posedge i_clk) begin
        t_tx_status want;
        t_tx_status got;
        if (i_rst_n && o_m_axis_tvalid === 1'b1 && i_m_axis_tready) begin
            got.line = o_m_axis_tdata[0];
            got.busy = o_m_axis_tdata[1];
            got.depth = o_m_axis_tdata[CNT_W+1:2];
            got.active = o_m_axis_tdata[CNT_W+2];
            if (tx_status_q.size() == 0) begin
                $display("%0t unexpected result beat: expected none, actual %h",
                         $time, o_m_axis_tdata);
                mismatches++;
            end else begin
                want = tx_status_q.pop_front();
                if (got.line !== want.line) begin
                    $display("%0t tx_line: expected %0d actual %0d",
                             $time, want.line, got.line);
                    mismatches++;
                end
                if (got.busy !== want.busy) begin
                    $display("%0t status: expected %0d actual %0d",
                             $time, want.busy, got.busy);
                    mismatches++;
                end
                if (got.depth !== want.depth) begin
                    $display("%0t queue_count: expected %0d actual %0d",
                             $time, want.depth, got.depth);
                    mismatches++;
                end
                if (got.active !== want.active) begin
                    $display("%0t active: expected %0d actual %0d",
                             $time, want.active, got.active);
                    mismatches++;
                end
            end
        end
    end

    // main sequence
    initial begin : run
        // shadow reset: queue contents stay unknown, never read before written
        q_rd = '0;
        q_wr = '0;
        q_fill = '0;
        shreg = '0;
        line_q = 1'b1;
        cfg_par_en = 1'b0;
        cfg_par_odd = 1'b0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_directed();
        test_parity_modes();
        test_random(8, 90);

        i_s_axis_tvalid = 1'b0;
        while (tx_status_q.size() != 0) @(posedge i_clk);
        repeat (5) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("[uart_tx_fifo_serializer] OK");
        end else begin
            $display("[uart_tx_fifo_serializer] ERROR");
        end
        $finish;
    end

    // run limit, several times the slowest legal run
    initial begin : watchdog
        #(20_000_000);
        $display("[uart_tx_fifo_serializer] ERROR");
        $finish;
    end

endmodule

@@ uart_tx_fifo_serializer.f @@
+incdir+rtl
rtl/utfs_pkg.sv
rtl/utfs_fifo.sv
rtl/utfs_frame_ser.sv
rtl/uart_tx_fifo_serializer.sv
rtl/utfs_checker.sv
tb/tb_uart_tx_fifo_serializer.sv
